>>> design/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg: shared types for the contiguous subsequence matcher
// Holds the input beat kind codes, the controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package csm_pkg;

  // Kind of an input beat, carried on tuser.
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  // Width of the result beat on the master side.
  localparam int unsigned OUT_W = 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TCHK,
    S_CMP,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pat_write;
    logic txt_write;
    logic cmp_init;
    logic cmp_step;
    logic cmp_finish;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cmp_needed;
    logic cmp_done;
    logic item_last;
    logic out_free;
  } status_t;

endpackage

>>> design/csm_ctrl.sv
// ----------------------------------------------------------------------------
// csm_ctrl: sequencing controller of the matcher
// Accepts input beats while idle, walks a text beat through the window check
// and the element-by-element compare, and hands a finished result to the
// output register.
// ----------------------------------------------------------------------------
module csm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tuser,
  output logic              s_tready,
  input  csm_pkg::status_t  status,
  output csm_pkg::cmd_t     cmd
);
  import csm_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == CMD_PATTERN) begin
            cmd.pat_write = 1'b1;
          end else begin
            cmd.txt_write = 1'b1;
            state_next    = S_TCHK;
          end
        end
      end
      S_TCHK: begin
        // Compare only when a complete pattern can still be found.
        if (status.cmp_needed) begin
          cmd.cmp_init = 1'b1;
          state_next   = S_CMP;
        end else if (status.item_last) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if (status.cmp_done) begin
          cmd.cmp_finish = 1'b1;
          state_next     = status.item_last ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        // Wait until the output register can take the result.
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/csm_dp.sv
// ----------------------------------------------------------------------------
// csm_dp: datapath of the matcher
// Holds the pattern memory, a circular text window memory, the pattern and
// text bookkeeping, the compare pipeline and the result output register.
// ----------------------------------------------------------------------------
module csm_dp #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [31:0]                 s_tdata,
  input  logic                        s_tlast,
  input  csm_pkg::cmd_t               cmd,
  output csm_pkg::status_t            status,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [csm_pkg::OUT_W-1:0]   m_tdata
);
  import csm_pkg::*;

  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [LW-1:0] MAX_LEN  = LW'(PATTERN_MAX);
  localparam logic [AW-1:0] LAST_IDX = AW'(PATTERN_MAX - 1);

  // Memories.
  logic [31:0] pat_mem [PATTERN_MAX];
  logic [31:0] win_mem [PATTERN_MAX];

  // Pattern and text bookkeeping.
  logic [LW-1:0] pat_len;
  logic          pat_complete;
  logic          pat_ovf;
  logic [AW-1:0] wp;
  logic [LW-1:0] seen_cnt;
  logic          found;
  logic          item_last;

  // Compare pipeline.
  logic [LW-1:0] cmp_j;
  logic [AW-1:0] cmp_tptr;
  logic          rd_valid;
  logic          mism;
  logic [31:0]   p_rdata;
  logic [31:0]   t_rdata;

  logic [LW-1:0] len_eff;
  logic          ovf_eff;
  logic          issue;
  logic [LW:0]   wp_ext;
  logic [LW:0]   len_ext;
  logic [LW:0]   start_sum;
  logic [AW-1:0] wp_inc;
  logic [AW-1:0] tptr_inc;
  logic          out_matched;

  // A pattern beat after a completed pattern starts a new one.
  assign len_eff = pat_complete ? '0 : pat_len;
  assign ovf_eff = pat_complete ? 1'b0 : pat_ovf;

  assign issue    = cmd.cmp_step && (cmp_j < pat_len);
  assign wp_inc   = (wp == LAST_IDX) ? '0 : wp + 1'b1;
  assign tptr_inc = (cmp_tptr == LAST_IDX) ? '0 : cmp_tptr + 1'b1;

  // Oldest element of the newest pat_len text elements in the circular window.
  assign wp_ext    = (LW + 1)'(wp);
  assign len_ext   = (LW + 1)'(pat_len);
  assign start_sum = (wp_ext >= len_ext) ? (wp_ext - len_ext)
                                         : (wp_ext + (LW + 1)'(PATTERN_MAX) - len_ext);

  assign out_matched = found && pat_complete && !pat_ovf && (pat_len != '0);

  // Status toward the controller.
  always_comb begin
    status.cmp_needed = pat_complete && !pat_ovf && (pat_len != '0) &&
                        (seen_cnt >= pat_len) && !found;
    status.cmp_done   = !(cmp_j < pat_len) && !rd_valid;
    status.item_last  = item_last;
    status.out_free   = !m_tvalid || m_tready;
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.pat_write && (len_eff < MAX_LEN)) begin
      pat_mem[len_eff[AW-1:0]] <= s_tdata;
    end
    if (cmd.txt_write) begin
      win_mem[wp] <= s_tdata;
    end
    if (issue) begin
      p_rdata <= pat_mem[cmp_j[AW-1:0]];
      t_rdata <= win_mem[cmp_tptr];
    end
  end

  // Pattern, text and compare control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len      <= '0;
      pat_complete <= 1'b0;
      pat_ovf      <= 1'b0;
      wp           <= '0;
      seen_cnt     <= '0;
      found        <= 1'b0;
      item_last    <= 1'b0;
      cmp_j        <= '0;
      cmp_tptr     <= '0;
      rd_valid     <= 1'b0;
      mism         <= 1'b0;
    end else begin
      // Pattern load; elements past the store depth only raise overflow.
      if (cmd.pat_write) begin
        if (len_eff < MAX_LEN) begin
          pat_len <= len_eff + 1'b1;
          pat_ovf <= ovf_eff;
        end else begin
          pat_len <= len_eff;
          pat_ovf <= 1'b1;
        end
        pat_complete <= s_tlast;
        if (s_tlast) begin
          seen_cnt <= '0;
          found    <= 1'b0;
        end
      end

      // Text beat enters the window.
      if (cmd.txt_write) begin
        wp        <= wp_inc;
        item_last <= s_tlast;
        if (seen_cnt < MAX_LEN) begin
          seen_cnt <= seen_cnt + 1'b1;
        end
      end

      // Compare sequence over the pattern elements.
      if (cmd.cmp_init) begin
        cmp_j    <= '0;
        cmp_tptr <= start_sum[AW-1:0];
        rd_valid <= 1'b0;
        mism     <= 1'b0;
      end else begin
        if (cmd.cmp_step) begin
          rd_valid <= issue;
          if (issue) begin
            cmp_j    <= cmp_j + 1'b1;
            cmp_tptr <= tptr_inc;
          end
          if (rd_valid && (p_rdata != t_rdata)) begin
            mism <= 1'b1;
          end
        end
        if (cmd.cmp_finish && !mism) begin
          found <= 1'b1;
        end
      end

      // Result loaded for output: the text count and the match flag start over.
      if (cmd.emit) begin
        seen_cnt <= '0;
        found    <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {(OUT_W - 2)'(0), pat_ovf, out_matched};
    end
  end

  // Checks on the datapath.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (pat_len <= MAX_LEN) && (seen_cnt <= MAX_LEN))
    else $error("pattern length or text count beyond store depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over an undelivered result");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("loaded result not presented");

  a_read_origin: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(cmd.cmp_step))
    else $error("compare data valid without a compare step");

endmodule

>>> design/contiguous_subsequence_matcher.sv
// ----------------------------------------------------------------------------
// contiguous_subsequence_matcher: pattern search over a stream of 32-bit words
// Loads a pattern, streams text through a window and reports on the text beat
// marked last whether the pattern occurred contiguously in that text.
// ----------------------------------------------------------------------------
// Pattern beat: taken in the idle state. Text beat: passes the window check state and,
// when the window is compared against a pattern of length L, the compare state (one
// element per cycle through the pattern and window memory read ports, skipped once
// a match is found). A text beat marked last then goes to the emit state, which loads
// the output register once an earlier result has left it; no beats are taken meanwhile.
// Reset (rst, synchronous) clears all control state; no clearing pass.
module contiguous_subsequence_matcher #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,  // [31:0] value
  input  logic                       s_tuser,  // [0] command
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [csm_pkg::OUT_W-1:0]  m_tdata   // [0] matched, [1] pattern_overflow
);
  import csm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing controller.
  csm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Memories, compare pipeline and output register.
  csm_dp #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
